// ----- hdl/cdm_pkg.sv -----
// Shared types and constants for the two-channel coincidence matcher.
`default_nettype none
package cdm_pkg;

    localparam int STORE_DEPTH_DEF = 1024;
    localparam int MAX_MATCHES_DEF = 64;
    localparam int FINE_BITS_DEF   = 8;

    localparam int TIME_W   = 48;
    localparam int FINE_W   = 16;
    localparam int CHARGE_W = 16;
    localparam int WINDOW_W = 16;
    localparam int TOF_W    = 26;
    localparam int FUNC_W   = 2;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(100);

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MATCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [TIME_W-1:0]   event_time;
        logic [FINE_W-1:0]   fine_time;
        logic [CHARGE_W-1:0] charge;
    } t_in;

    typedef struct packed {
        logic signed [TOF_W-1:0] time_of_flight;
        logic [CHARGE_W-1:0]     charge_first;
        logic [CHARGE_W-1:0]     charge_second;
        logic [TIME_W-1:0]       time_first;
        logic                    last;
        logic                    truncated;
        logic                    dropped;
    } t_out;

    typedef struct packed {
        logic [TIME_W-1:0]   event_time;
        logic [FINE_W-1:0]   fine_time;
        logic [CHARGE_W-1:0] charge;
    } t_entry;

    // classification of one stored entry against the current query
    typedef struct packed {
        logic                    early;
        logic                    late;
        logic signed [TOF_W-1:0] tof;
        logic [CHARGE_W-1:0]     charge_second;
    } t_eval;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIFF,
        S_EVAL,
        S_FLUSH
    } t_state;

endpackage
`default_nettype wire

// ----- hdl/two_channel_coincidence_matcher_core.sv -----
// Load and clear finish in S_IDLE; a match goes S_READ, S_DIFF, S_EVAL per
//   stored entry examined, then S_FLUSH, and can wait on output stalls; the first
//   result appears after the second in-window entry is evaluated or at scan end.
// One request at a time; entries go through the single read port and the
//   shared compare unit one after another.
// Reset: synchronous active low; store empty, window 100, no clearing pass.
`default_nettype none
module two_channel_coincidence_matcher_core #(
    parameter int STORE_DEPTH        = cdm_pkg::STORE_DEPTH_DEF,
    parameter int MAX_MATCHES        = cdm_pkg::MAX_MATCHES_DEF,
    parameter int FINE_FRACTION_BITS = cdm_pkg::FINE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire cdm_pkg::t_in                  i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output cdm_pkg::t_out                      o_out_data,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [cdm_pkg::WINDOW_W-1:0]  i_cfg_data
);
    import cdm_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int OW = $clog2(STORE_DEPTH + 1);
    localparam int CW = $clog2(MAX_MATCHES + 1);

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] s);
        return (s == AW'(STORE_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    t_state              r_state, n_state;
    logic [AW-1:0]       r_wslot, n_wslot;
    logic [AW-1:0]       r_sstart, n_sstart;
    logic [OW-1:0]       r_occ, n_occ;
    logic                r_drop, n_drop;
    logic [WINDOW_W-1:0] r_window;
    logic [AW-1:0]       r_idx, n_idx;
    logic [OW-1:0]       r_rem, n_rem;
    logic                r_head, n_head;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_trunc, n_trunc;
    t_in                 r_q, n_q;
    logic                r_pend_valid, n_pend_valid;
    t_out                r_pend, n_pend;
    logic                r_out_valid, n_out_valid;
    t_out                r_out, n_out;

    logic   in_acc;
    logic   out_free;
    logic   ram_we;
    logic   eval_load;
    t_entry ram_wdata;
    t_entry ram_rdata;
    t_eval  ev;
    t_out   new_res;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    assign ram_wdata.event_time = i_in_data.event_time;
    assign ram_wdata.fine_time  = i_in_data.fine_time;
    assign ram_wdata.charge     = i_in_data.charge;
    assign ram_we    = in_acc && (i_in_data.func == FUNC_LOAD) && (r_occ < OW'(STORE_DEPTH));
    assign eval_load = (r_state == S_DIFF);

    cdm_store #(
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wslot),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    cdm_eval #(
        .FINE_FRACTION_BITS (FINE_FRACTION_BITS)
    ) u_eval (
        .i_clk        (i_clk),
        .i_load       (eval_load),
        .i_entry      (ram_rdata),
        .i_query_time (r_q.event_time),
        .i_query_fine (r_q.fine_time),
        .i_window     (r_window),
        .o_res        (ev)
    );

    always_comb begin
        new_res.time_of_flight = ev.tof;
        new_res.charge_first   = r_q.charge;
        new_res.charge_second  = ev.charge_second;
        new_res.time_first     = r_q.event_time;
        new_res.last           = 1'b0;
        new_res.truncated      = 1'b0;
        new_res.dropped        = r_drop;
    end

    always_comb begin
        n_state      = r_state;
        n_wslot      = r_wslot;
        n_sstart     = r_sstart;
        n_occ        = r_occ;
        n_drop       = r_drop;
        n_idx        = r_idx;
        n_rem        = r_rem;
        n_head       = r_head;
        n_cnt        = r_cnt;
        n_trunc      = r_trunc;
        n_q          = r_q;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.func)
                        FUNC_LOAD: begin
                            if (ram_we) begin
                                n_wslot = f_next(r_wslot);
                                n_occ   = r_occ + 1'b1;
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        FUNC_MATCH: begin
                            n_q     = i_in_data;
                            n_idx   = r_sstart;
                            n_rem   = r_occ;
                            n_head  = 1'b1;
                            n_cnt   = '0;
                            n_trunc = 1'b0;
                            n_state = (r_occ == '0) ? S_FLUSH : S_READ;
                        end
                        FUNC_CLEAR: begin
                            n_wslot  = '0;
                            n_sstart = '0;
                            n_occ    = '0;
                            n_drop   = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_DIFF;
            end
            S_DIFF: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_head && ev.early) begin
                    // retire early entries at the head of the ring
                    n_sstart = f_next(r_idx);
                    n_occ    = r_occ - 1'b1;
                    n_idx    = f_next(r_idx);
                    n_rem    = r_rem - 1'b1;
                    n_state  = (r_rem == OW'(1)) ? S_FLUSH : S_READ;
                end else begin
                    n_head = 1'b0;
                    if (ev.late) begin
                        n_state = S_FLUSH;
                    end else if (ev.early) begin
                        n_idx   = f_next(r_idx);
                        n_rem   = r_rem - 1'b1;
                        n_state = (r_rem == OW'(1)) ? S_FLUSH : S_READ;
                    end else if (r_cnt == CW'(MAX_MATCHES)) begin
                        n_trunc = 1'b1;
                        n_state = S_FLUSH;
                    end else if (!r_pend_valid || out_free) begin
                        // the held result is known not to be last once another match exists
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out       = r_pend;
                        end
                        n_pend_valid = 1'b1;
                        n_pend       = new_res;
                        n_cnt        = r_cnt + 1'b1;
                        n_idx        = f_next(r_idx);
                        n_rem        = r_rem - 1'b1;
                        n_state      = (r_rem == OW'(1)) ? S_FLUSH : S_READ;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out           = r_pend;
                    n_out.last      = 1'b1;
                    n_out.truncated = r_trunc;
                    n_pend_valid    = 1'b0;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wslot      <= '0;
            r_sstart     <= '0;
            r_occ        <= '0;
            r_drop       <= 1'b0;
            r_window     <= WINDOW_RESET;
            r_head       <= 1'b0;
            r_cnt        <= '0;
            r_trunc      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wslot      <= n_wslot;
            r_sstart     <= n_sstart;
            r_occ        <= n_occ;
            r_drop       <= n_drop;
            r_head       <= n_head;
            r_cnt        <= n_cnt;
            r_trunc      <= n_trunc;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid) begin
                r_window <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    // the window register only takes writes outside reset
    assign o_cfg_ready = i_rst_n;

endmodule
`default_nettype wire

// ----- hdl/cdm_store.sv -----
// Ring store of second-channel events: one write port, one registered read port.
`default_nettype none
module cdm_store #(
    parameter int   DEPTH = cdm_pkg::STORE_DEPTH_DEF,
    localparam int  AW    = $clog2(DEPTH)
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire cdm_pkg::t_entry i_wdata,
    input  wire logic [AW-1:0]   i_raddr,
    output cdm_pkg::t_entry      o_rdata
);
    import cdm_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- hdl/cdm_eval.sv -----
// Shared compare unit: coarse delta, window test and saturated time of flight.
`default_nettype none
module cdm_eval #(
    parameter int FINE_FRACTION_BITS = cdm_pkg::FINE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_load,
    input  wire cdm_pkg::t_entry               i_entry,
    input  wire logic [cdm_pkg::TIME_W-1:0]    i_query_time,
    input  wire logic [cdm_pkg::FINE_W-1:0]    i_query_fine,
    input  wire logic [cdm_pkg::WINDOW_W-1:0]  i_window,
    output cdm_pkg::t_eval                     o_res
);
    import cdm_pkg::*;

    localparam int DW    = TIME_W + 1;
    localparam int SUM_W = 64;

    logic signed [DW-1:0]    r_delta;
    logic [FINE_W-1:0]       r_fine_s;
    logic [CHARGE_W-1:0]     r_chg_s;

    logic signed [DW-1:0]    w_pos;
    logic signed [DW-1:0]    w_neg;
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-TOF_W:0]    sum_hi;
    logic                    in_range;

    // stage 1: coarse difference, stored minus query
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_delta  <= $signed({1'b0, i_entry.event_time}) - $signed({1'b0, i_query_time});
            r_fine_s <= i_entry.fine_time;
            r_chg_s  <= i_entry.charge;
        end
    end

    // stage 2: window test and time of flight in parallel
    always_comb begin
        w_pos    = $signed({{(DW-WINDOW_W){1'b0}}, i_window});
        w_neg    = -w_pos;
        sum      = ($signed({{(SUM_W-DW){r_delta[DW-1]}}, r_delta}) <<< FINE_FRACTION_BITS)
                 + $signed({{(SUM_W-FINE_W){1'b0}}, r_fine_s})
                 - $signed({{(SUM_W-FINE_W){1'b0}}, i_query_fine});
        sum_hi   = sum[SUM_W-1:TOF_W-1];
        in_range = (&sum_hi) | (~|sum_hi);

        o_res.early         = r_delta < w_neg;
        o_res.late          = r_delta > w_pos;
        o_res.charge_second = r_chg_s;
        if (in_range) begin
            o_res.tof = sum[TOF_W-1:0];
        end else if (sum[SUM_W-1]) begin
            o_res.tof = {1'b1, {(TOF_W-1){1'b0}}};
        end else begin
            o_res.tof = {1'b0, {(TOF_W-1){1'b1}}};
        end
    end

endmodule
`default_nettype wire

// ----- hdl/cdm_checker.sv -----
// Port-level checks for the coincidence matcher, bound to the top level.
`default_nettype none
module cdm_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          i_in_stall,
    input wire cdm_pkg::t_in  i_in_data,
    input wire logic          i_out_valid,
    input wire logic          i_out_stall,
    input wire cdm_pkg::t_out i_out_data
);
    import cdm_pkg::*;

    // a held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // a match request keeps the block busy for its scan
    a_match_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall && (i_in_data.func == FUNC_MATCH) |=> i_in_stall)
        else $error("match request did not occupy the block");

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.truncated |-> i_out_data.last)
        else $error("truncated set on a result that is not last");

    // the final result of a query must still follow
    a_nonlast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.last |-> i_in_stall)
        else $error("block idle before the last result of a query");

endmodule

bind two_channel_coincidence_matcher_core cdm_checker u_cdm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking testbench for the two-channel coincidence matcher core.
`timescale 1ns / 100ps
module testbench;
    import cdm_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int  SCAN_PAUSE  = 3 * STORE_DEPTH_DEF + 64;
    localparam int  STALL_LIMIT = 20000;
    localparam longint TOF_TOP    = (longint'(1) <<< (TOF_W - 1)) - 1;
    localparam longint TOF_BOTTOM = -(longint'(1) <<< (TOF_W - 1));
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    t_in                 i_in_data   = '0;
    logic                i_out_stall = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic [WINDOW_W-1:0] i_cfg_data  = WINDOW_RESET;
    logic                o_in_stall;
    logic                o_out_valid;
    t_out                o_out_data;
    logic                o_cfg_ready;

    two_channel_coincidence_matcher_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // shadow copy of the event store and its pointers
    logic [TIME_W-1:0]   st_time [STORE_DEPTH_DEF];
    logic [31:0]         st_fine_charge [STORE_DEPTH_DEF];
    int unsigned         wr_slot    = 0;
    int unsigned         scan_head  = 0;
    int unsigned         fill       = 0;
    bit                  drop_seen  = 1'b0;
    logic [WINDOW_W-1:0] win_now    = WINDOW_RESET;

    t_in  request_queue [$];
    t_out expected_hits [$];
    t_out want_hit;
    int   error_count = 0;
    int   send_gap    = 0;
    int   hold_left   = 0;
    int   idle_pct    = 0;
    int   stall_pct   = 0;
    int   quiet_cycles = 0;

    function automatic int unsigned bump(input int unsigned s);
        return (s + 1 >= STORE_DEPTH_DEF) ? 0 : s + 1;
    endfunction

    function automatic logic [15:0] rand16();
        return 16'($urandom());
    endfunction

    function automatic longint coarse_gap(input int unsigned slot, input logic [TIME_W-1:0] t);
        return longint'(st_time[slot]) - longint'(t);
    endfunction

    // update the shadow store with one accepted request, queue the matches it yields
    task automatic apply_request(input t_in req);
        longint      w, d, tof;
        int unsigned idx, k;
        bit          cut;
        t_out        hit;
        t_out        hits [$];
        w   = longint'(win_now);
        cut = 1'b0;
        case (req.func)
            FUNC_LOAD: begin
                if (fill >= STORE_DEPTH_DEF) begin
                    drop_seen = 1'b1;
                end else begin
                    st_time[wr_slot]        = req.event_time;
                    st_fine_charge[wr_slot] = {req.fine_time, req.charge};
                    wr_slot = bump(wr_slot);
                    fill++;
                end
            end
            FUNC_CLEAR: begin
                wr_slot   = 0;
                scan_head = 0;
                fill      = 0;
                drop_seen = 1'b0;
            end
            FUNC_MATCH: begin
                // retire entries at the head that fell out of the window
                while (fill > 0 && coarse_gap(scan_head, req.event_time) < -w) begin
                    scan_head = bump(scan_head);
                    fill--;
                end
                idx = scan_head;
                for (k = 0; k < fill; k++) begin
                    d = coarse_gap(idx, req.event_time);
                    if (d > w)
                        break;
                    if (d >= -w) begin
                        if (hits.size() >= MAX_MATCHES_DEF) begin
                            cut = 1'b1;
                            break;
                        end
                        tof = d * (longint'(1) <<< FINE_BITS_DEF)
                            + longint'(st_fine_charge[idx][31:16]) - longint'(req.fine_time);
                        if (tof > TOF_TOP)
                            tof = TOF_TOP;
                        if (tof < TOF_BOTTOM)
                            tof = TOF_BOTTOM;
                        hit.time_of_flight = tof[TOF_W-1:0];
                        hit.charge_first   = req.charge;
                        hit.charge_second  = st_fine_charge[idx][15:0];
                        hit.time_first     = req.event_time;
                        hit.last           = 1'b0;
                        hit.truncated      = 1'b0;
                        hit.dropped        = drop_seen;
                        hits = {hits, hit};
                    end
                    idx = bump(idx);
                end
                if (hits.size() > 0) begin
                    hit = hits[hits.size() - 1];
                    hit.last      = 1'b1;
                    hit.truncated = cut;
                    hits[hits.size() - 1] = hit;
                end
                expected_hits = {expected_hits, hits};
            end
            default: ;
        endcase
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                apply_request(i_in_data);
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (request_queue.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= request_queue.pop_front();
                    if ($urandom_range(0, 99) < idle_pct)
                        send_gap = $urandom_range(1, 18);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            hold_left = $urandom_range(0, 17);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic flag_mismatch(input string field, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        error_count++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endtask

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_hits.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result: expected none, actual %h", $time,
                         o_out_data);
            end else begin
                want_hit = expected_hits.pop_front();
                if (o_out_data.time_of_flight !== want_hit.time_of_flight)
                    flag_mismatch("time_of_flight", $signed(want_hit.time_of_flight),
                                  $signed(o_out_data.time_of_flight));
                if (o_out_data.charge_first !== want_hit.charge_first)
                    flag_mismatch("charge_first", want_hit.charge_first,
                                  o_out_data.charge_first);
                if (o_out_data.charge_second !== want_hit.charge_second)
                    flag_mismatch("charge_second", want_hit.charge_second,
                                  o_out_data.charge_second);
                if (o_out_data.time_first !== want_hit.time_first)
                    flag_mismatch("time_first", want_hit.time_first, o_out_data.time_first);
                if (o_out_data.last !== want_hit.last)
                    flag_mismatch("last", want_hit.last, o_out_data.last);
                if (o_out_data.truncated !== want_hit.truncated)
                    flag_mismatch("truncated", want_hit.truncated, o_out_data.truncated);
                if (o_out_data.dropped !== want_hit.dropped)
                    flag_mismatch("dropped", want_hit.dropped, o_out_data.dropped);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_request(input logic [FUNC_W-1:0] func, input logic [TIME_W-1:0] t,
                                input logic [FINE_W-1:0] fine, input logic [CHARGE_W-1:0] chg);
        t_in r;
        r.func       = func;
        r.event_time = t;
        r.fine_time  = fine;
        r.charge     = chg;
        request_queue = {request_queue, r};
    endtask

    function automatic logic [TIME_W-1:0] pick_base();
        logic [TIME_W-1:0] b;
        b = TIME_W'({$urandom(), $urandom()});
        // keep headroom so a phase never wraps the coarse time
        if (b > TIME_MAX - 48'h100_0000)
            b = b - 48'h100_0000;
        return b;
    endfunction

    // wait for every request and result to pass, then for the longest scan
    task automatic settle();
        while (request_queue.size() > 0 || i_in_valid || expected_hits.size() > 0)
            @(posedge i_clk);
        repeat (SCAN_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [WINDOW_W-1:0] w);
        settle();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        win_now = w;
    endtask

    // time-ordered two-channel traffic; a match is held back until the store
    // has been loaded past its window, with some noise and misordered requests
    task automatic random_traffic(input int count, input int max_step);
        logic [TIME_W-1:0] now, back;
        t_in  held [$];
        t_in  r;
        int   done, pick;
        now  = pick_base();
        done = 0;
        push_request(FUNC_CLEAR, now, rand16(), rand16());
        while (done < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                push_request(FUNC_UNUSED, TIME_W'({$urandom(), $urandom()}), rand16(),
                             rand16());
            end else begin
                done++;
                if (pick < 7) begin
                    back = TIME_W'($urandom_range(0, 3 * int'(win_now) + 5));
                    push_request(FUNC_LOAD, (now > back) ? now - back : '0, rand16(),
                                 rand16());
                end else if (pick < 9) begin
                    push_request(FUNC_MATCH,
                                 now + TIME_W'($urandom_range(0, int'(win_now))),
                                 rand16(), rand16());
                end else if (pick < 10) begin
                    push_request(FUNC_CLEAR, now, rand16(), rand16());
                end else begin
                    now = now + TIME_W'($urandom_range(0, max_step));
                    if ($urandom_range(0, 1)) begin
                        while (held.size() > 0
                               && held[0].event_time + TIME_W'(win_now) < now) begin
                            request_queue = {request_queue, held[0]};
                            held.delete(0);
                        end
                        push_request(FUNC_LOAD, now, rand16(), rand16());
                    end else begin
                        r.func       = FUNC_MATCH;
                        r.event_time = now;
                        r.fine_time  = rand16();
                        r.charge     = rand16();
                        held = {held, r};
                    end
                end
            end
        end
        while (held.size() > 0) begin
            request_queue = {request_queue, held[0]};
            held.delete(0);
        end
    endtask

    initial begin
        logic [TIME_W-1:0] base;
        int i;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset window of 100
        idle_pct  = 20;
        stall_pct = 4;
        push_request(FUNC_UNUSED, TIME_MAX, 16'hFFFF, 16'hFFFF);
        push_request(FUNC_MATCH, 48'd500, 16'h0000, 16'h0000);     // empty store
        push_request(FUNC_LOAD, 48'd1000, 16'h0000, 16'h0000);
        push_request(FUNC_LOAD, 48'd1050, 16'hFFFF, 16'hFFFF);
        push_request(FUNC_LOAD, 48'd1100, 16'h0080, 16'h1234);
        push_request(FUNC_LOAD, 48'd1200, 16'h0000, 16'h0001);
        push_request(FUNC_LOAD, 48'd1201, 16'h0000, 16'h0002);
        push_request(FUNC_MATCH, 48'd1100, 16'h0000, 16'hFFFF);    // both window edges
        push_request(FUNC_LOAD, 48'd900, 16'h0001, 16'h0003);      // out of order, not at head
        push_request(FUNC_MATCH, 48'd1150, 16'hFFFF, 16'h0000);    // retires the oldest
        push_request(FUNC_CLEAR, '0, 16'h0000, 16'h0000);
        push_request(FUNC_LOAD, TIME_MAX, 16'hFFFF, 16'hAAAA);
        push_request(FUNC_MATCH, TIME_MAX - 48'd100, 16'h0000, 16'h5555);
        push_request(FUNC_MATCH, TIME_MAX, 16'hFFFF, 16'h0000);
        push_request(FUNC_LOAD, '0, 16'h8000, 16'h8000);
        push_request(FUNC_MATCH, '0, 16'h0000, 16'h0000);          // head is far late
        push_request(FUNC_MATCH, TIME_MAX, 16'h1234, 16'h4321);
        push_request(FUNC_CLEAR, TIME_MAX, 16'hFFFF, 16'hFFFF);
        push_request(FUNC_MATCH, '0, 16'h0000, 16'h0000);

        // exact coincidences only, no idling
        idle_pct  = 0;
        stall_pct = 0;
        write_window('0);
        random_traffic(40, 2);

        // widest window: exactly the match limit, then one past it
        idle_pct  = 30;
        stall_pct = 6;
        write_window(16'hFFFF);
        base = pick_base();
        push_request(FUNC_CLEAR, base, 16'h0000, 16'h0000);
        for (i = 0; i < MAX_MATCHES_DEF; i++)
            push_request(FUNC_LOAD, base + TIME_W'(i), rand16(), rand16());
        push_request(FUNC_MATCH, base + 48'd32, rand16(), rand16());
        push_request(FUNC_LOAD, base + TIME_W'(MAX_MATCHES_DEF), rand16(), rand16());
        push_request(FUNC_MATCH, base + 48'd32, rand16(), rand16());
        random_traffic(40, 40000);

        // retire the oldest entries at the head, then load more and scan again
        idle_pct  = 10;
        stall_pct = 3;
        write_window(16'd10);
        base = pick_base();
        push_request(FUNC_CLEAR, base, 16'h0000, 16'h0000);
        for (i = 0; i < 40; i++)
            push_request(FUNC_LOAD, base + TIME_W'(2 * i), rand16(), rand16());
        push_request(FUNC_MATCH, base + 48'd40, rand16(), rand16());
        for (i = 0; i < 30; i++)
            push_request(FUNC_LOAD, base + 48'd80 + TIME_W'(2 * i), rand16(), rand16());
        push_request(FUNC_MATCH, base + 48'd100, rand16(), rand16());
        push_request(FUNC_CLEAR, base, rand16(), rand16());
        push_request(FUNC_LOAD, base + 48'd500, rand16(), rand16());
        push_request(FUNC_MATCH, base + 48'd500, rand16(), rand16());

        idle_pct  = 15;
        stall_pct = 4;
        base = TIME_W'($urandom_range(1, 2000));
        write_window(base[WINDOW_W-1:0]);
        random_traffic(120, 2 * int'(base[WINDOW_W-1:0]));

        // last part runs at full rate
        idle_pct  = 0;
        stall_pct = 0;
        write_window(16'd1);
        random_traffic(40, 3);

        settle();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
